[rtl/core/arpp_pkg.sv]
// ----------------------------------------------------------------------------
// arpp_pkg: shared types and constants of the wind and rain pulse processor
// Opcodes, register indexes, reset values and divider sizing.
// ----------------------------------------------------------------------------
package arpp_pkg;

  // Item opcodes.
  typedef enum logic [2:0] {
    OP_WIND_EDGE  = 3'd0,
    OP_RAIN_EDGE  = 3'd1,
    OP_READ_SPEED = 3'd2,
    OP_READ_GUST  = 3'd3,
    OP_READ_RAIN  = 3'd4
  } opcode_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIND_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_RAIN_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_CALM_TIMEOUT  = 2'd2;
  localparam logic [1:0] REG_SPEED_SCALE   = 2'd3;

  localparam int ADDR_BITS = 4;

  // Register reset values.
  localparam logic [7:0]  WIND_DEBOUNCE_RST = 8'd10;
  localparam logic [9:0]  RAIN_DEBOUNCE_RST = 10'd100;
  localparam logic [15:0] CALM_TIMEOUT_RST  = 16'd3000;
  localparam logic [11:0] SPEED_SCALE_RST   = 12'd1492;

  // The dividend is speed_scale * 256, so it spans 20 bits.
  localparam int DIVIDEND_BITS = 20;
  localparam int STEP_BITS     = 5;
  localparam logic [STEP_BITS-1:0] DIV_STEPS = 5'd20;

  // Control and status exchanged with the divider.
  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/core/arpp_div.sv]
// ----------------------------------------------------------------------------
// arpp_div: iterative restoring divider
// One compare and subtract per cycle, one quotient bit per step.
// ----------------------------------------------------------------------------
module arpp_div
  import arpp_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  input  logic [TIME_BITS-1:0] divisor,
  output div_rsp_t             rsp
);

  localparam int CW = (TIME_BITS > DIVIDEND_BITS + 1) ? TIME_BITS : DIVIDEND_BITS + 1;

  logic                     busy;
  logic [STEP_BITS-1:0]     steps;
  logic [DIVIDEND_BITS-1:0] rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [TIME_BITS-1:0]     div_q;
  logic                     done;

  logic [CW-1:0] trial;
  logic [CW-1:0] div_ext;
  logic [CW-1:0] diff;
  logic          fits;

  // The partial remainder stays below both the divisor and 2^20.
  assign trial   = CW'({rem, quo[DIVIDEND_BITS-1]});
  assign div_ext = CW'(div_q);
  assign fits    = (trial >= div_ext);
  assign diff    = trial - div_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= DIV_STEPS;
        rem   <= '0;
        quo   <= req.dividend;
        div_q <= divisor;
      end else if (busy) begin
        rem   <= fits ? diff[DIVIDEND_BITS-1:0] : trial[DIVIDEND_BITS-1:0];
        quo   <= {quo[DIVIDEND_BITS-2:0], fits};
        steps <= steps - STEP_BITS'(1);
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[rtl/core/anemometer_rain_pulse_processor.sv]
// ----------------------------------------------------------------------------
// anemometer_rain_pulse_processor: wind and rain gauge pulse processor
// Debounces reed-switch edges, derives wind speed and gust, counts rain tips.
// ----------------------------------------------------------------------------
// Usage:
// Each input word carries an opcode and a millisecond timestamp and yields
// exactly one output word. Input words are taken with in_valid while
// in_stall is low; output words leave with out_valid and are held while
// out_stall is high. The block works on one word at a time: in_stall is low
// only in the idle state.
// A wind edge that passes its debounce goes from accept to output through
// decode, divider start, 20 divider steps, finish and the load of the
// output register; every other word goes through decode and load. A new
// word is accepted only after the previous one is in the output register.
// The 20-step restoring divider computes scale*256/elapsed for the wind
// speed.
// The output register parts the two sides: the next word is accepted while
// a finished word still waits for the receiver. If the receiver stalls, the
// following result waits in the done state and in_stall stays high.
// Reset (synchronous, active high) restores the register defaults, clears
// the times, speed, gust and rain count, sets the indicator level high and
// empties the output register. The APB port is ready every cycle.
// ----------------------------------------------------------------------------
module anemometer_rain_pulse_processor
  import arpp_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           opcode,
  input  logic [31:0]          now_ms,
  // Output channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          read_value,
  output logic                 edge_accepted,
  output logic                 indicator
);

  // Configuration registers.
  logic [7:0]  wind_debounce_ms;
  logic [9:0]  rain_debounce_ms;
  logic [15:0] calm_timeout_ms;
  logic [11:0] speed_scale;

  // Block state.
  logic [TIME_BITS-1:0] last_wind_time;
  logic [TIME_BITS-1:0] last_rain_time;
  logic [15:0]          wind_speed;
  logic [15:0]          gust_max;
  logic [15:0]          rain_tips;
  logic                 indicator_level;

  // Sequencer and the latched input word.
  state_t               state;
  logic [2:0]           op_q;
  logic [TIME_BITS-1:0] now_q;

  // Result waiting to be loaded into the output register.
  logic [15:0] res_value;
  logic        res_accepted;
  logic        res_indicator;

  // Divider interface.
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [TIME_BITS-1:0] div_divisor;

  logic [TIME_BITS-1:0] wind_elapsed;
  logic [TIME_BITS-1:0] rain_elapsed;
  logic                 wind_pass;
  logic                 rain_pass;
  logic                 calm;
  logic [15:0]          speed_sat;
  logic                 cfg_write;
  logic                 out_free;

  // Elapsed times wrap modulo 2^TIME_BITS.
  assign wind_elapsed = now_q - last_wind_time;
  assign rain_elapsed = now_q - last_rain_time;
  assign wind_pass    = (wind_elapsed > TIME_BITS'(wind_debounce_ms));
  assign rain_pass    = (rain_elapsed > TIME_BITS'(rain_debounce_ms));
  assign calm         = (wind_elapsed > TIME_BITS'(calm_timeout_ms));

  // The quotient saturates at full scale of Q8.8.
  assign speed_sat = (div_rsp.quotient[DIVIDEND_BITS-1:16] != '0) ? 16'hFFFF :
                     div_rsp.quotient[15:0];

  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (paddr[3:2])
      REG_WIND_DEBOUNCE: prdata = 32'(wind_debounce_ms);
      REG_RAIN_DEBOUNCE: prdata = 32'(rain_debounce_ms);
      REG_CALM_TIMEOUT:  prdata = 32'(calm_timeout_ms);
      REG_SPEED_SCALE:   prdata = 32'(speed_scale);
      default:           prdata = '0;
    endcase
  end

  arpp_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .divisor(div_divisor),
    .rsp    (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wind_debounce_ms <= WIND_DEBOUNCE_RST;
      rain_debounce_ms <= RAIN_DEBOUNCE_RST;
      calm_timeout_ms  <= CALM_TIMEOUT_RST;
      speed_scale      <= SPEED_SCALE_RST;
      last_wind_time   <= '0;
      last_rain_time   <= '0;
      wind_speed       <= '0;
      gust_max         <= '0;
      rain_tips        <= '0;
      indicator_level  <= 1'b1;
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      div_req.start    <= 1'b0;
    end else begin
      div_req.start <= 1'b0;

      if (cfg_write) begin
        case (paddr[3:2])
          REG_WIND_DEBOUNCE: wind_debounce_ms <= pwdata[7:0];
          REG_RAIN_DEBOUNCE: rain_debounce_ms <= pwdata[9:0];
          REG_CALM_TIMEOUT:  calm_timeout_ms  <= pwdata[15:0];
          REG_SPEED_SCALE:   speed_scale      <= pwdata[11:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q  <= opcode;
            now_q <= TIME_BITS'(now_ms);
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          // Default result: nothing read, no edge taken, current indicator.
          res_value     <= '0;
          res_accepted  <= 1'b0;
          res_indicator <= indicator_level;
          state         <= ST_DONE;
          case (op_q)
            OP_WIND_EDGE: begin
              if (wind_pass) begin
                div_req.start    <= 1'b1;
                div_req.dividend <= {speed_scale, 8'h00};
                div_divisor      <= wind_elapsed;
                state            <= ST_DIV;
              end
            end
            OP_RAIN_EDGE: begin
              if (rain_pass) begin
                if (rain_tips != 16'hFFFF) begin
                  rain_tips <= rain_tips + 16'd1;
                end
                last_rain_time <= now_q;
                res_accepted   <= 1'b1;
              end
            end
            OP_READ_SPEED: begin
              if (calm) begin
                wind_speed <= '0;
                res_value  <= '0;
              end else begin
                res_value <= wind_speed;
              end
            end
            OP_READ_GUST: begin
              res_value <= gust_max;
              gust_max  <= '0;
            end
            OP_READ_RAIN: begin
              res_value <= rain_tips;
              rain_tips <= '0;
            end
            default: ;
          endcase
        end

        ST_DIV: begin
          if (div_rsp.done) begin
            wind_speed <= speed_sat;
            if (speed_sat > gust_max) begin
              gust_max <= speed_sat;
            end
            last_wind_time  <= now_q;
            indicator_level <= !indicator_level;
            res_accepted    <= 1'b1;
            res_indicator   <= !indicator_level;
            state           <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            read_value    <= res_value;
            edge_accepted <= res_accepted;
            indicator     <= res_indicator;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[tb/anemometer_rain_pulse_processor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anemometer_rain_pulse_processor_test: self-checking bench of the pulse processor
// Opens with a table of directed words: reset behavior, debounce boundaries,
// timestamp wrap, saturation, unused opcodes and the register extremes.
// Random phases follow, each under a fresh register setting. Every output
// word is checked against its typed table entry or against a predictor
// that keeps its own copy of the registers and the sensor state.
// ----------------------------------------------------------------------------
module anemometer_rain_pulse_processor_test;
  import arpp_pkg::*;

  // Opcodes that the block must treat as no-ops.
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  // Register settings that the directed table steps through.
  localparam logic [1:0] SET_RESET = 2'd0;
  localparam logic [1:0] SET_SLOW  = 2'd1;
  localparam logic [1:0] SET_FAST  = 2'd2;

  localparam int unsigned Q88_ONE       = 256;
  localparam int          DIRECTED_ROWS = 25;
  localparam int          RANDOM_PHASES = 5;
  localparam int          PHASE_WORDS   = 220;
  localparam int          STRETCH       = 40;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          CYCLE_LIMIT   = 2000000;

  // One output word as the predictor sees it.
  typedef struct packed {
    logic [15:0] value;
    logic        accepted;
    logic        level;
  } out_word_t;

  // One row of the directed table. Where typed is set, want holds the
  // expected word; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]  setting;
    logic [2:0]  op;
    logic [31:0] ts;
    logic        typed;
    out_word_t   want;
  } row_t;

  localparam out_word_t FROM_MODEL = '0;

  // Raw write data for each setting. Most slow and fast words carry junk in
  // the upper bits on purpose: the block must keep only each register's width.
  localparam logic [31:0] SETTING_WORDS [3][4] = '{
    '{32'(WIND_DEBOUNCE_RST), 32'(RAIN_DEBOUNCE_RST),
      32'(CALM_TIMEOUT_RST), 32'(SPEED_SCALE_RST)},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000},
    '{32'hFFFF_FF00, 32'hFFFF_FC00, 32'hFFFF_0000, 32'h0000_0FFF}
  };

  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // Reads straight after reset return zero with the indicator high.
    '{SET_RESET, OP_READ_SPEED, 32'd0,          1'b1, '{16'd0, 1'b0, 1'b1}},
    '{SET_RESET, OP_READ_GUST,  32'd0,          1'b1, '{16'd0, 1'b0, 1'b1}},
    '{SET_RESET, OP_READ_RAIN,  32'd0,          1'b1, '{16'd0, 1'b0, 1'b1}},
    // The first edge is timed against zero; exactly the debounce is too soon.
    '{SET_RESET, OP_WIND_EDGE,  32'd10,         1'b1, '{16'd0, 1'b0, 1'b1}},
    '{SET_RESET, OP_WIND_EDGE,  32'd11,         1'b1, '{16'd0, 1'b1, 1'b0}},
    '{SET_RESET, OP_READ_SPEED, 32'd12,         1'b0, FROM_MODEL},
    // A huge interval gives speed zero; the next edge is timed across the wrap.
    '{SET_RESET, OP_WIND_EDGE,  32'hFFFF_FFFF,  1'b1, '{16'd0, 1'b1, 1'b1}},
    '{SET_RESET, OP_WIND_EDGE,  32'd10,         1'b1, '{16'd0, 1'b1, 1'b0}},
    '{SET_RESET, OP_READ_GUST,  32'd20,         1'b0, FROM_MODEL},
    '{SET_RESET, OP_READ_GUST,  32'd21,         1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_RESET, OP_RAIN_EDGE,  32'd100,        1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_RESET, OP_RAIN_EDGE,  32'd101,        1'b1, '{16'd0, 1'b1, 1'b0}},
    '{SET_RESET, OP_READ_RAIN,  32'd102,        1'b1, '{16'd1, 1'b0, 1'b0}},
    // One millisecond past the calm timeout the speed reads zero.
    '{SET_RESET, OP_READ_SPEED, 32'd3011,       1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_RESET, OP_SPARE_HI,   32'hFFFF_FFFF,  1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_RESET, OP_SPARE_LO,   32'd0,          1'b1, '{16'd0, 1'b0, 1'b0}},
    // Widest debounce windows and a speed scale of zero.
    '{SET_SLOW,  OP_WIND_EDGE,  32'd265,        1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_SLOW,  OP_WIND_EDGE,  32'd266,        1'b1, '{16'd0, 1'b1, 1'b1}},
    '{SET_SLOW,  OP_RAIN_EDGE,  32'd1124,       1'b1, '{16'd0, 1'b0, 1'b1}},
    '{SET_SLOW,  OP_RAIN_EDGE,  32'd1125,       1'b1, '{16'd0, 1'b1, 1'b1}},
    // No debounce, no calm time and the largest scale: speed saturates.
    '{SET_FAST,  OP_WIND_EDGE,  32'd267,        1'b1, '{16'd0, 1'b1, 1'b0}},
    '{SET_FAST,  OP_WIND_EDGE,  32'd267,        1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_FAST,  OP_READ_SPEED, 32'd267,        1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{SET_FAST,  OP_READ_SPEED, 32'd268,        1'b1, '{16'd0, 1'b0, 1'b0}},
    '{SET_FAST,  OP_READ_GUST,  32'd269,        1'b1, '{16'hFFFF, 1'b0, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] read_value;
  logic        edge_accepted;
  logic        indicator;

  // Shadow registers and sensor state of the predictor.
  logic [7:0]  cfg_wind_deb;
  logic [9:0]  cfg_rain_deb;
  logic [15:0] cfg_calm;
  logic [11:0] cfg_scale;
  logic [31:0] last_wind_ms;
  logic [31:0] last_rain_ms;
  logic [15:0] speed_q88;
  logic [15:0] gust_q88;
  logic [15:0] tip_count;
  logic        led_level;

  out_word_t   want_words [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  anemometer_rain_pulse_processor dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .edge_accepted (edge_accepted),
    .indicator     (indicator)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog. A hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL anemometer_rain_pulse_processor");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // Works out the word that the block must return for one input word, and
  // advances the predictor's state as the block would.
  function automatic out_word_t predict_word(input logic [2:0] op,
                                             input logic [31:0] ts);
    out_word_t   w;
    logic [31:0] el;
    logic [63:0] q;
    w = '0;
    case (op)
      OP_WIND_EDGE: begin
        el = ts - last_wind_ms;
        if (el > 32'(cfg_wind_deb)) begin
          q = (64'(cfg_scale) * 64'(Q88_ONE)) / 64'(el);
          speed_q88 = (q > 64'h0000_FFFF) ? 16'hFFFF : q[15:0];
          if (speed_q88 > gust_q88) gust_q88 = speed_q88;
          led_level = ~led_level;
          last_wind_ms = ts;
          w.accepted = 1'b1;
        end
      end
      OP_RAIN_EDGE: begin
        el = ts - last_rain_ms;
        if (el > 32'(cfg_rain_deb)) begin
          if (tip_count != 16'hFFFF) tip_count = tip_count + 16'd1;
          last_rain_ms = ts;
          w.accepted = 1'b1;
        end
      end
      OP_READ_SPEED: begin
        // The calm timeout zeroes the stored speed, not just the reading.
        if (ts - last_wind_ms > 32'(cfg_calm)) speed_q88 = '0;
        w.value = speed_q88;
      end
      OP_READ_GUST: begin
        w.value = gust_q88;
        gust_q88 = '0;
      end
      OP_READ_RAIN: begin
        w.value = tip_count;
        tip_count = '0;
      end
      default: begin
      end
    endcase
    w.level = led_level;
    return w;
  endfunction

  // Offers one word on the input channel, after a random gap if idle_on is set,
  // and waits for the accepting edge, where the expectation is queued.
  task automatic send_word(input logic [2:0] op, input logic [31:0] ts,
                           input logic typed, input out_word_t want);
    int        gap;
    out_word_t model_word;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    now_ms   <= ts;
    do @(posedge clk); while (in_stall);
    model_word = predict_word(op, ts);
    want_words.push_back(typed ? want : model_word);
  endtask

  // Stops offering words and waits until every expected word has come back,
  // which leaves the block idle and ready for register writes.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (want_words.size() != 0) @(posedge clk);
  endtask

  // One register write over the configuration port, then a read back of the
  // same register, which must return the value cut to the register width.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] kept;
    kept = '0;
    case (idx)
      REG_WIND_DEBOUNCE: begin
        cfg_wind_deb = data[7:0];
        kept = 32'(data[7:0]);
      end
      REG_RAIN_DEBOUNCE: begin
        cfg_rain_deb = data[9:0];
        kept = 32'(data[9:0]);
      end
      REG_CALM_TIMEOUT: begin
        cfg_calm = data[15:0];
        kept = 32'(data[15:0]);
      end
      REG_SPEED_SCALE: begin
        cfg_scale = data[11:0];
        kept = 32'(data[11:0]);
      end
      default: begin
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) report_mismatch("register read back", prdata, kept);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [1:0] s);
    write_reg(REG_WIND_DEBOUNCE, SETTING_WORDS[s][REG_WIND_DEBOUNCE]);
    write_reg(REG_RAIN_DEBOUNCE, SETTING_WORDS[s][REG_RAIN_DEBOUNCE]);
    write_reg(REG_CALM_TIMEOUT,  SETTING_WORDS[s][REG_CALM_TIMEOUT]);
    write_reg(REG_SPEED_SCALE,   SETTING_WORDS[s][REG_SPEED_SCALE]);
  endtask

  // Register values for a random phase lean on the ends of the range.
  function automatic logic [31:0] pick_setting(input int unsigned lo,
                                               input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Output side. A word leaves at an edge where out_valid is high and
  // out_stall is low; after each one the receiver draws a fresh stall.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (want_words.size() == 0) begin
        report_mismatch("output word with nothing expected", 32'(read_value), 0);
      end else begin
        want = want_words.pop_front();
        if (read_value !== want.value)
          report_mismatch("read_value", 32'(read_value), 32'(want.value));
        if (edge_accepted !== want.accepted)
          report_mismatch("edge_accepted", 32'(edge_accepted), 32'(want.accepted));
        if (indicator !== want.level)
          report_mismatch("indicator", 32'(indicator), 32'(want.level));
      end
      stall_left = idle_on ? $urandom_range(0, 6) : 0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end
    out_stall <= (stall_left != 0);
  end

  initial begin
    logic [1:0]  cur_setting;
    logic [2:0]  op;
    logic [31:0] clock_ms;
    int unsigned span;
    int unsigned r;

    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    opcode   <= OP_WIND_EDGE;
    now_ms   <= '0;

    // The predictor starts from the block's reset state.
    cfg_wind_deb = WIND_DEBOUNCE_RST;
    cfg_rain_deb = RAIN_DEBOUNCE_RST;
    cfg_calm     = CALM_TIMEOUT_RST;
    cfg_scale    = SPEED_SCALE_RST;
    last_wind_ms = '0;
    last_rain_ms = '0;
    speed_q88    = '0;
    gust_q88     = '0;
    tip_count    = '0;
    led_level    = 1'b1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. A change of setting drains the block first, since
    // registers may only be written while it is idle.
    cur_setting = SET_RESET;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].setting != cur_setting) begin
        drain_results();
        apply_setting(DIRECTED[i].setting);
        cur_setting = DIRECTED[i].setting;
      end
      send_word(DIRECTED[i].op, DIRECTED[i].ts, DIRECTED[i].typed, DIRECTED[i].want);
    end

    clock_ms = DIRECTED[DIRECTED_ROWS-1].ts;

    // Random phases, each under its own register setting. Timestamps often
    // step by amounts near the debounce or calm window of the opcode, so that
    // both outcomes of every timing test come up often; now and then a fully
    // random stamp jumps across the wrap or backwards.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      write_reg(REG_WIND_DEBOUNCE,
                (32'($urandom) & 32'hFFFF_FF00) | pick_setting(0, 255));
      write_reg(REG_RAIN_DEBOUNCE,
                (32'($urandom) & 32'hFFFF_FC00) | pick_setting(0, 1023));
      write_reg(REG_CALM_TIMEOUT,
                (32'($urandom) & 32'hFFFF_0000) | pick_setting(0, 65535));
      write_reg(REG_SPEED_SCALE,
                (32'($urandom) & 32'hFFFF_F000) | pick_setting(1, 4095));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % STRETCH == 0) idle_on = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_WIND_EDGE;
        else if (r < 60) op = OP_RAIN_EDGE;
        else if (r < 75) op = OP_READ_SPEED;
        else if (r < 85) op = OP_READ_GUST;
        else if (r < 95) op = OP_READ_RAIN;
        else begin
          case ($urandom_range(0, 2))
            0: op = OP_SPARE_LO;
            1: op = OP_SPARE_MID;
            default: op = OP_SPARE_HI;
          endcase
        end
        case (op)
          OP_WIND_EDGE: span = 32'(cfg_wind_deb);
          OP_RAIN_EDGE: span = 32'(cfg_rain_deb);
          default: span = 32'(cfg_calm);
        endcase
        r = $urandom_range(0, 99);
        if (r < 45) clock_ms = clock_ms + $urandom_range(0, 2 * span + 4);
        else if (r < 75) clock_ms = clock_ms + $urandom_range(0, 4000);
        else if (r < 92) clock_ms = clock_ms + $urandom_range(0, 140000);
        else clock_ms = $urandom;
        send_word(op, clock_ms, 1'b0, FROM_MODEL);
      end
    end

    // Let every expected word come back, then give the block a little time
    // to show any stray output before the verdict.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS anemometer_rain_pulse_processor");
    end else begin
      $display("FAIL anemometer_rain_pulse_processor");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/arpp_pkg.sv
rtl/core/arpp_div.sv
rtl/core/anemometer_rain_pulse_processor.sv
tb/anemometer_rain_pulse_processor_test.sv
